// File: sv/move_to_front_byte_coder_top_defines.svh
// Assertion macros shared by the move-to-front coder modules
`ifndef MOVE_TO_FRONT_BYTE_CODER_TOP_DEFINES_SVH
`define MOVE_TO_FRONT_BYTE_CODER_TOP_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset
`define MTFBC_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("move-to-front coder check failed");

// Next-cycle implication, checked on the rising clock edge outside reset
`define MTFBC_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("move-to-front coder check failed");

`endif

// File: sv/mtfbc_pkg.sv
// Types and constants shared by the move-to-front coder modules
package mtfbc_pkg;

   // Width of one symbol and of one list position on the ports
   localparam int unsigned BYTE_W = 8;

   // Direction register codes
   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Controller states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FETCH,
      ST_SCAN,
      ST_DELIVER
   } mtfbc_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;     // take the request word, start the lookup
      logic fetch_load; // decode: symbol at the position is in the read register
      logic scan_step;  // compare, write back the carried entry, advance
      logic init_step;  // write one identity entry after reset
      logic out_load;   // load the result into the output register
   } mtfbc_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic mode;       // current direction
      logic miss;       // request byte lies outside the alphabet
      logic hit;        // read entry matches the searched symbol
      logic init_last;  // last identity entry is being written
      logic out_free;   // output register can take a result this cycle
   } mtfbc_sts_type;

endpackage

// File: sv/mtfbc_ctrl.sv
// Controller state machine of the move-to-front coder
`include "move_to_front_byte_coder_top_defines.svh"

module mtfbc_ctrl import mtfbc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  mtfbc_sts_type sts,
   output mtfbc_cmd_type cmd
);

   mtfbc_state_type state_ff;
   mtfbc_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (sts.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (sts.mode == MODE_DECODE) state_in = ST_FETCH;
               else if (sts.miss)           state_in = ST_DELIVER;
               else                         state_in = ST_SCAN;
            end
         end
         ST_FETCH: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (sts.hit) state_in = sts.out_free ? ST_IDLE : ST_DELIVER;
         end
         ST_DELIVER: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_FETCH: begin
            cmd.fetch_load = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.out_load  = sts.hit & sts.out_free;
         end
         ST_DELIVER: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   `MTFBC_ASSERT_IMP(a_load_needs_room, cmd.out_load, sts.out_free)
   `MTFBC_ASSERT_IMP(a_one_command, 1'b1,
      $onehot0({cmd.accept, cmd.fetch_load, cmd.scan_step, cmd.init_step}))
   `MTFBC_ASSERT_NXT(a_scan_goes_on, (state_ff == ST_SCAN) && !sts.hit,
      state_ff == ST_SCAN)

endmodule

// File: sv/mtfbc_dp.sv
// Datapath of the move-to-front coder: list memory, scan registers, output word
`include "move_to_front_byte_coder_top_defines.svh"

module mtfbc_dp import mtfbc_pkg::*; #(
   parameter int unsigned ALPHABET_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   input  logic              csr_we,
   input  logic              csr_wdata,
   input  mtfbc_cmd_type     cmd,
   output mtfbc_sts_type     sts
);

   localparam int unsigned AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
   localparam logic [AW-1:0]   LAST   = AW'(ALPHABET_SIZE - 1);
   localparam logic [BYTE_W:0] SIZE_W = (BYTE_W + 1)'(ALPHABET_SIZE);

   // List order, front at entry 0
   logic [BYTE_W-1:0] order_mem [ALPHABET_SIZE];

   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     k_ff, k_in;        // position of the entry in rd_data_ff
   logic [BYTE_W-1:0] key_ff, key_in;    // symbol being searched
   logic [BYTE_W-1:0] carry_ff, carry_in; // entry that moves one place back
   logic              mode_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;

   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              in_range;
   logic [AW-1:0]     pos_sat;
   logic              hit;

   // Request decode: range check and saturated position
   assign in_range = {1'b0, req_in_byte} < SIZE_W;
   assign pos_sat  = in_range ? req_in_byte[AW-1:0] : LAST;
   assign hit      = (rd_data_ff == key_ff);

   // Memory port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = k_ff;
      wr_data = carry_ff;
      if (cmd.accept) begin
         rd_en   = 1'b1;
         rd_addr = (mode_ff == MODE_DECODE) ? pos_sat : '0;
      end else if (cmd.fetch_load) begin
         rd_en   = 1'b1;
         rd_addr = '0;
      end else if (cmd.scan_step) begin
         wr_en   = 1'b1;
         rd_en   = !hit;
         rd_addr = k_ff + AW'(1);
      end else if (cmd.init_step) begin
         wr_en   = 1'b1;
         wr_data = BYTE_W'(k_ff);
      end
   end

   // List memory with registered read
   always_ff @(posedge clock) begin
      if (wr_en) order_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= order_mem[rd_addr];
   end

   // Scan registers next values
   always_comb begin
      k_in     = k_ff;
      key_in   = key_ff;
      carry_in = carry_ff;
      if (cmd.accept) begin
         k_in     = '0;
         key_in   = req_in_byte;
         carry_in = req_in_byte;
      end else if (cmd.fetch_load) begin
         k_in     = '0;
         key_in   = rd_data_ff;
         carry_in = rd_data_ff;
      end else if (cmd.scan_step && !hit) begin
         k_in     = k_ff + AW'(1);
         carry_in = rd_data_ff;
      end else if (cmd.init_step) begin
         k_in     = k_ff + AW'(1);
      end
   end

   // Position counter doubles as the init sweep pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
      end else begin
         k_ff <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      carry_ff <= carry_in;
   end

   // Direction register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCODE;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // Output word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)              rsp_valid_in = 1'b1;
      else if (!rsp_stall)           rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_byte_ff <= (mode_ff == MODE_DECODE) ? key_ff : BYTE_W'(k_ff);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   // Status back to the controller
   assign sts.mode      = mode_ff;
   assign sts.miss      = !in_range;
   assign sts.hit       = hit;
   assign sts.init_last = (k_ff == LAST);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   // The list is a permutation: the searched symbol turns up by the last entry
   `MTFBC_ASSERT_IMP(a_scan_in_bounds, cmd.scan_step && !hit, k_ff != LAST)
   // A stalled word stays put
   `MTFBC_ASSERT_NXT(a_rsp_held, rsp_valid_ff && rsp_stall,
      rsp_valid_ff && $stable(rsp_byte_ff))
   `MTFBC_ASSERT_NXT(a_load_sets_valid, cmd.out_load, rsp_valid_ff)

endmodule

// File: sv/move_to_front_byte_coder_top.sv
// Top level of the move-to-front byte coder
//
//   channel   ports                           direction  meaning
//   request   req_valid req_stall req_in_byte  in         byte (encode) / position (decode)
//   response  rsp_valid rsp_stall rsp_out_byte out        position (encode) / byte (decode)
//   control   csr_we csr_wdata                 in         direction: 0 encode, 1 decode
//
// An encoded byte is searched for from the front of the list; a decoded position is first
// read out and its symbol is then searched for; an encoded byte outside the alphabet skips
// the search. The list sits in a single-port-write memory, so the search and the shift
// walk it one entry per cycle. After reset the list is rebuilt with req_stall high.
// A response stall holds the finished word; a new request can still be taken meanwhile.
module move_to_front_byte_coder_top import mtfbc_pkg::*; #(
   parameter int unsigned ALPHABET_SIZE = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   input  logic              csr_we,
   input  logic              csr_wdata
);

   mtfbc_cmd_type cmd;
   mtfbc_sts_type sts;

   // Sequencer
   mtfbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // List memory and result path
   mtfbc_dp #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts)
   );

endmodule
